// ----- design/lccd_pkg.sv -----
// ----------------------------------------------------------------------------
// lccd_pkg: shared definitions for the limited coin change dispenser
// Field widths, inventory size, operation and result codes, and the
// request and response structs of the shared divider.
// ----------------------------------------------------------------------------
package lccd_pkg;

  // Inventory size and derived index widths.
  localparam int unsigned SLOTS    = 8;
  localparam int unsigned SlotIdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SlotCntW = $clog2(SLOTS + 1);

  // Field widths of the stream payloads.
  localparam int unsigned SlotW   = 3;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned AmountW = 20;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 56;

  // One quotient bit per divider step.
  localparam int unsigned DivSteps = AmountW;
  localparam int unsigned DivStepW = $clog2(DivSteps);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_CHANGE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACK      = 2'd0,
    KIND_DISPENSE = 2'd1,
    KIND_STATUS   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACK,
    ST_FETCH,
    ST_DIV,
    ST_CLAMP,
    ST_MUL,
    ST_SUB,
    ST_EMIT,
    ST_STATUS
  } state_e;

  typedef struct packed {
    logic               start;
    logic [AmountW-1:0] dividend;
    logic [ValueW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [AmountW-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- design/limited_coin_change_dispenser_top.sv -----
// A load beat is accepted and written to its slot, then the acknowledge is sent from ST_ACK.
// A change beat walks the slots in index order; each slot that holds a coin value waits on the
// shared bit-serial divider, and a slot that pays out coins also emits a dispense entry. Unused
// slots are skipped. A stalled output holds the walk until the result beat is taken.
// One item is in work at a time; the input is not ready until its last result is registered.
// Reset (asynchronous, active low) clears every slot value and count, so all slots are unused.
// ----------------------------------------------------------------------------
// limited_coin_change_dispenser_top: coin inventory with greedy change payout
// Holds a value and a count per slot, loads slots on request, and walks the
// slots in index order to pay out an amount with the coins at hand.
// ----------------------------------------------------------------------------
module limited_coin_change_dispenser_top
  import lccd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: slot[2:0], denomination[18:3], coin_count[34:19], amount[54:35], zero pad[55]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: operation[0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: coin_value[15:0], dispensed[31:16], remaining[51:32], short_of_change[52], pad[55:53]
  output logic [OutDataW-1:0] m_axis_tdata,
  // tuser: kind[1:0]
  output logic [1:0]          m_axis_tuser,
  output logic                m_axis_tlast
);

  // Input beat fields.
  op_e                in_op;
  logic [SlotW-1:0]   in_slot;
  logic [ValueW-1:0]  in_den;
  logic [CountW-1:0]  in_cnt;
  logic [AmountW-1:0] in_amount;
  logic               in_fire;

  assign in_op     = op_e'(s_axis_tuser);
  assign in_slot   = s_axis_tdata[2:0];
  assign in_den    = s_axis_tdata[18:3];
  assign in_cnt    = s_axis_tdata[34:19];
  assign in_amount = s_axis_tdata[54:35];
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  // Inventory and walk state.
  logic [ValueW-1:0]          val_q [SLOTS];
  logic [CountW-1:0]          cnt_q [SLOTS];
  state_e                     state_q, state_d;
  logic [SlotCntW-1:0]        walk_q;
  logic [SlotIdxW-1:0]        walk_idx;
  logic                       walk_done;
  logic                       walk_inc;
  logic [AmountW-1:0]         rem_q;
  logic [CountW-1:0]          give_q, give_d;
  logic [AmountW-1:0]         prod_q;
  logic [ValueW-1:0]          cur_val;
  logic [CountW-1:0]          cur_cnt;
  logic [SlotIdxW+SlotW-1:0]  slot_ext;
  logic                       slot_ok;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;
  logic [2*ValueW-1:0]        prod_full;

  // Output register.
  logic                       out_valid_q;
  logic [OutDataW-1:0]        out_data_q, out_data_d;
  kind_e                      out_kind_q;
  logic                       out_last_q;
  logic                       out_free;
  logic                       out_load;
  kind_e                      out_kind;

  assign walk_idx  = walk_q[SlotIdxW-1:0];
  assign walk_done = (walk_q == SlotCntW'(SLOTS));
  assign cur_val   = val_q[walk_idx];
  assign cur_cnt   = cnt_q[walk_idx];
  assign slot_ext  = (SlotIdxW + SlotW)'(in_slot);
  assign slot_ok   = (32'(in_slot) < SLOTS);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign prod_full = (2*ValueW)'(give_q) * (2*ValueW)'(cur_val);

  // Pay out the quotient unless the slot holds fewer coins.
  assign give_d = (div_rsp.quotient > AmountW'(cur_cnt)) ? cur_cnt
                                                         : div_rsp.quotient[CountW-1:0];

  lccd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer: next state and control strobes.
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = rem_q;
    div_req.divisor  = cur_val;
    out_load         = 1'b0;
    out_kind         = KIND_ACK;
    walk_inc         = 1'b0;
    s_axis_tready    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_fire) begin
          state_d = (in_op == OP_LOAD) ? ST_ACK : ST_FETCH;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          out_load = 1'b1;
          out_kind = KIND_ACK;
          state_d  = ST_IDLE;
        end
      end
      ST_FETCH: begin
        if (walk_done) begin
          state_d = ST_STATUS;
        end else if (cur_val == '0) begin
          walk_inc = 1'b1;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (give_d == '0) begin
          walk_inc = 1'b1;
          state_d  = ST_FETCH;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_SUB;
      end
      ST_SUB: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_kind = KIND_DISPENSE;
          walk_inc = 1'b1;
          state_d  = ST_FETCH;
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          out_load = 1'b1;
          out_kind = KIND_STATUS;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Payload of the next result beat.
  always_comb begin
    out_data_d = '0;
    case (out_kind)
      KIND_DISPENSE: begin
        out_data_d[15:0]  = cur_val;
        out_data_d[31:16] = give_q;
      end
      KIND_STATUS: begin
        out_data_d[51:32] = rem_q;
        out_data_d[52]    = (rem_q != '0);
      end
      default: begin
        out_data_d = '0;
      end
    endcase
  end

  // Control registers: state, walk index, output valid and the slot inventory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        val_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        walk_q <= '0;
      end else if (walk_inc) begin
        walk_q <= walk_q + 1'b1;
      end
      if (in_fire && (in_op == OP_LOAD) && slot_ok) begin
        val_q[slot_ext[SlotIdxW-1:0]] <= in_den;
        cnt_q[slot_ext[SlotIdxW-1:0]] <= in_cnt;
      end
      if (state_q == ST_SUB) begin
        cnt_q[walk_idx] <= cur_cnt - give_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers: remaining amount, payout, its product and the output beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rem_q <= in_amount;
    end else if (state_q == ST_SUB) begin
      rem_q <= rem_q - prod_q;
    end
    if (state_q == ST_CLAMP) begin
      give_q <= give_d;
    end
    // The product never exceeds the remaining amount, so 20 bits hold it.
    if (state_q == ST_MUL) begin
      prod_q <= prod_full[AmountW-1:0];
    end
    if (out_load) begin
      out_kind_q <= out_kind;
      out_last_q <= (out_kind != KIND_DISPENSE);
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("result beat carries an undefined kind");

  a_status_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_STATUS)) |->
      (m_axis_tdata[52] == (m_axis_tdata[51:32] != '0)))
    else $error("shortfall flag disagrees with the remaining amount");

  a_dispense_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_DISPENSE)) |->
      ((m_axis_tdata[31:16] != '0) && (m_axis_tdata[15:0] != '0)))
    else $error("dispense entry with no coins or no coin value");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_DISPENSE)))
    else $error("last flag does not match the result kind");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside of a division step");
`endif

endmodule

// ----- design/lccd_div.sv -----
// ----------------------------------------------------------------------------
// lccd_div: radix-2 restoring divider
// Divides the remaining amount by a coin value, one quotient bit per cycle.
// The divisor is never zero when a division is started.
// ----------------------------------------------------------------------------
module lccd_div
  import lccd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivStepW-1:0] step_q, step_d;
  logic [AmountW-1:0]  dvd_q, dvd_d;
  logic [ValueW-1:0]   dvs_q, dvs_d;
  logic [ValueW-1:0]   part_q, part_d;
  logic [ValueW:0]     trial;
  logic [ValueW:0]     diff;
  logic                qbit;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign trial = {part_q, dvd_q[AmountW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = (trial >= {1'b0, dvs_q});

  // Step sequencing and the shifting dividend/quotient register.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    part_d = part_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      part_d = '0;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[AmountW-2:0], qbit};
      part_d = qbit ? diff[ValueW-1:0] : trial[ValueW-1:0];
      step_d = step_q + 1'b1;
      if (step_q == DivStepW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    part_q <= part_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule
